### rtl/led_blink_pattern_sequencer_unit_macros.svh
// Assertion helpers used by the sequencer engine RTL.
// Each macro expects aclk and aresetn to exist in the module that uses it.
`ifndef LED_BLINK_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication.
`define LBPS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lbps_pkg.sv
package lbps_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int NOW_W             = 32;
    localparam int MODE_W            = 3;
    localparam int STEP_W            = 3;
    localparam int DELAY_W           = 11;
    localparam int FUNC_W            = 2;

    localparam logic [FUNC_W-1:0] FUNC_TICK        = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_MODE    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RAISE_ERROR = 2'd2;

    localparam logic [MODE_W-1:0] MODE_OFF    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FAST   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEART  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DOUBLE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_TRIPLE = 3'd5;

    localparam logic [DELAY_W-1:0] DLY_FAST       = 11'd120;
    localparam logic [DELAY_W-1:0] DLY_HEART_ON   = 11'd60;
    localparam logic [DELAY_W-1:0] DLY_HEART_OFF  = 11'd1940;
    localparam logic [DELAY_W-1:0] DLY_DOUBLE     = 11'd120;
    localparam logic [DELAY_W-1:0] DLY_DOUBLE_OFF = 11'd1200;
    localparam logic [DELAY_W-1:0] DLY_TRIPLE     = 11'd100;
    localparam logic [DELAY_W-1:0] DLY_TRIPLE_OFF = 11'd900;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [NOW_W-1:0]  now_ms;
        logic [MODE_W-1:0] new_mode;
    } item_t;

    typedef struct packed {
        logic [MODE_W-1:0] current_mode;
        logic              led_lit;
        logic              pin_level;
    } result_t;

    typedef struct packed {
        logic               lit;
        logic [DELAY_W-1:0] delay;
        logic [STEP_W-1:0]  next_step;
    } sched_t;

    // One due tick of a blinking mode: new LED state, time to the next
    // deadline and the following step. Out-of-range steps act as the last one.
    function automatic sched_t pattern_next(input logic [MODE_W-1:0] mode,
                                            input logic [STEP_W-1:0] step,
                                            input logic lit);
        sched_t r;
        r = '{lit: lit, delay: '0, next_step: step};
        case (mode)
            MODE_FAST: begin
                r = '{lit: ~lit, delay: DLY_FAST, next_step: step};
            end
            MODE_HEART: begin
                if (step == 3'd0) begin
                    r = '{lit: 1'b1, delay: DLY_HEART_ON, next_step: 3'd1};
                end else begin
                    r = '{lit: 1'b0, delay: DLY_HEART_OFF, next_step: 3'd0};
                end
            end
            MODE_DOUBLE: begin
                case (step)
                    3'd0:    r = '{lit: 1'b1, delay: DLY_DOUBLE, next_step: 3'd1};
                    3'd1:    r = '{lit: 1'b0, delay: DLY_DOUBLE, next_step: 3'd2};
                    3'd2:    r = '{lit: 1'b1, delay: DLY_DOUBLE, next_step: 3'd3};
                    default: r = '{lit: 1'b0, delay: DLY_DOUBLE_OFF, next_step: 3'd0};
                endcase
            end
            MODE_TRIPLE: begin
                if (step < 3'd5) begin
                    r = '{lit: ~step[0], delay: DLY_TRIPLE, next_step: step + 3'd1};
                end else begin
                    r = '{lit: 1'b0, delay: DLY_TRIPLE_OFF, next_step: 3'd0};
                end
            end
            default: begin
                r = '{lit: lit, delay: '0, next_step: step};
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/lbps_in_reg.sv
module lbps_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  lbps_pkg::item_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output lbps_pkg::item_t out_item
);

    logic            valid_reg;
    logic            valid_next;
    lbps_pkg::item_t item_reg;

    // The register refills in the same cycle that its content moves on.
    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !out_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

### rtl/lbps_engine.sv
`include "led_blink_pattern_sequencer_unit_macros.svh"

module lbps_engine #(
    parameter int TIME_BITS = lbps_pkg::TIME_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  lbps_pkg::item_t   in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output lbps_pkg::result_t out_result
);

    logic                          active_low_reg;
    logic [lbps_pkg::MODE_W-1:0]   mode_reg;
    logic [lbps_pkg::MODE_W-1:0]   mode_next;
    logic [lbps_pkg::STEP_W-1:0]   step_reg;
    logic [lbps_pkg::STEP_W-1:0]   step_next;
    logic [TIME_BITS-1:0]          deadline_reg;
    logic [TIME_BITS-1:0]          deadline_next;
    logic                          lit_reg;
    logic                          lit_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    lbps_pkg::result_t             result_reg;

    logic                          take;
    logic [TIME_BITS-1:0]          now_val;
    logic [TIME_BITS-1:0]          elapsed;
    logic [lbps_pkg::MODE_W-1:0]   req_mode;
    lbps_pkg::sched_t              sched;

    logic                                  tick_off;
    logic [TIME_BITS+lbps_pkg::STEP_W-1:0] sched_state;
    logic [lbps_pkg::MODE_W:0]             state_view;
    logic [lbps_pkg::MODE_W:0]             result_view;

    assign in_ready       = !out_valid_reg || out_ready;
    assign take           = in_valid && in_ready;
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_comb begin
        mode_next     = mode_reg;
        step_next     = step_reg;
        deadline_next = deadline_reg;
        lit_next      = lit_reg;
        now_val       = TIME_BITS'(in_item.now_ms);
        // Wrap-safe compare: the deadline has passed when the difference is
        // non-negative as a signed value.
        elapsed       = now_val - deadline_reg;
        sched         = lbps_pkg::pattern_next(mode_reg, step_reg, lit_reg);
        req_mode      = (in_item.func == lbps_pkg::FUNC_RAISE_ERROR) ?
                        lbps_pkg::MODE_TRIPLE : in_item.new_mode;
        if (take) begin
            case (in_item.func)
                lbps_pkg::FUNC_TICK: begin
                    if ((mode_reg inside {[lbps_pkg::MODE_FAST:lbps_pkg::MODE_TRIPLE]})
                        && !elapsed[TIME_BITS-1]) begin
                        lit_next      = sched.lit;
                        deadline_next = now_val + TIME_BITS'(sched.delay);
                        step_next     = sched.next_step;
                    end
                end
                lbps_pkg::FUNC_SET_MODE, lbps_pkg::FUNC_RAISE_ERROR: begin
                    if (req_mode <= lbps_pkg::MODE_TRIPLE && req_mode != mode_reg) begin
                        mode_next     = req_mode;
                        step_next     = '0;
                        deadline_next = now_val;
                        if (req_mode == lbps_pkg::MODE_OFF) begin
                            lit_next = 1'b0;
                        end
                        if (req_mode == lbps_pkg::MODE_SOLID) begin
                            lit_next = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_low_reg <= 1'b1;
            mode_reg       <= lbps_pkg::MODE_OFF;
            step_reg       <= '0;
            deadline_reg   <= '0;
            lit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                active_low_reg <= cfg_data;
            end
            mode_reg      <= mode_next;
            step_reg      <= step_next;
            deadline_reg  <= deadline_next;
            lit_reg       <= lit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            result_reg <= '{current_mode: mode_next,
                            led_lit:      lit_next,
                            pin_level:    lit_next ^ active_low_reg};
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    assign tick_off    = take && in_item.func == lbps_pkg::FUNC_TICK
                         && mode_reg == lbps_pkg::MODE_OFF;
    assign sched_state = {deadline_reg, step_reg};
    assign state_view  = {mode_reg, lit_reg};
    assign result_view = {result_reg.current_mode, result_reg.led_lit};

    `LBPS_ASSERT_IMP(a_mode_range, 1'b1, mode_reg <= lbps_pkg::MODE_TRIPLE, "mode out of range")
    `LBPS_ASSERT_IMP(a_off_dark, mode_reg == lbps_pkg::MODE_OFF, !lit_reg, "LED lit in off mode")
    `LBPS_ASSERT_IMP(a_solid_lit, mode_reg == lbps_pkg::MODE_SOLID, lit_reg, "LED dark when solid")
    `LBPS_ASSERT_NEXT(a_off_tick, tick_off, $stable(sched_state), "tick changed idle state")
    `LBPS_ASSERT_NEXT(a_result_mode, take, result_view == state_view, "result disagrees with state")

endmodule

### rtl/led_blink_pattern_sequencer_unit.sv
// Status LED blink pattern sequencer.
// Input stream (s_*): one beat per event. s_tuser carries the event kind
// (tick, set mode, raise error); s_tdata carries the millisecond time and the
// requested mode. Every accepted beat yields exactly one result beat on m_*:
// the pin level after polarity, the logical LED state and the mode in force.
// The polarity register is written through cfg_valid/cfg_data, which is always
// ready; write it only while no events are in flight.
// An accepted input beat waits in the input register, then passes through the
// pattern logic into the result register, from which its result beat is offered.
// Throughput is one event per cycle while m_tready is high, since the deadline
// compare, the pattern lookup and the state update are all combinational logic.
// A stalled m_tready holds the result register; the input register still takes
// one more beat if it is empty, after which s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) selects the off mode with the LED dark, the
// step and deadline at zero and active-low polarity, and empties both registers.
module led_blink_pattern_sequencer_unit #(
    parameter int TIME_BITS = lbps_pkg::TIME_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // active_low
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,       // [31:0] now_ms, [34:32] new_mode, rest zero
    input  logic [1:0]  s_tuser,       // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata        // [0] pin_level, [1] led_lit, [4:2] current_mode
);

    lbps_pkg::item_t   s_item;
    lbps_pkg::item_t   q_item;
    logic              q_valid;
    logic              q_ready;
    lbps_pkg::result_t result;

    assign cfg_ready = 1'b1;

    assign s_item = '{func:     s_tuser,
                      now_ms:   s_tdata[31:0],
                      new_mode: s_tdata[34:32]};

    lbps_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    lbps_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (result)
    );

    assign m_tdata = {3'b000, result};

endmodule
